[rtl/core/slcd_pkg.sv]
// Shared types, constants and the glyph table of the segment display store controller.
package slcd_pkg;

   localparam int STORE_ENTRIES = 16;
   localparam int IDX_W         = $clog2(STORE_ENTRIES);
   localparam int QUEUE_DEPTH   = 2;
   localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

   // Command codes.
   localparam logic [2:0] OP_PUT   = 3'd0;
   localparam logic [2:0] OP_BATT  = 3'd1;
   localparam logic [2:0] OP_MARK  = 3'd2;
   localparam logic [2:0] OP_POINT = 3'd3;
   localparam logic [2:0] OP_CLEAR = 3'd4;

   // Section codes.
   localparam logic [1:0] SEC_RIGHT = 2'd0;
   localparam logic [1:0] SEC_MID   = 2'd1;
   localparam logic [1:0] SEC_LEFT  = 2'd2;
   localparam logic [1:0] SEC_NONE  = 2'd3;

   // Section geometry: digit slots count down from the base entry.
   localparam logic [2:0] RIGHT_DIGITS = 3'd6;
   localparam logic [2:0] SIDE_DIGITS  = 3'd5;
   localparam logic [IDX_W-1:0] RIGHT_BASE = 4'd5;
   localparam logic [IDX_W-1:0] MID_BASE   = 4'd10;
   localparam logic [IDX_W-1:0] LEFT_BASE  = 4'd15;

   // Decimal point groups start at these entries and span three bytes.
   localparam logic [IDX_W-1:0] RIGHT_POINT_BASE = 4'd0;
   localparam logic [IDX_W-1:0] MID_POINT_BASE   = 4'd6;
   localparam logic [IDX_W-1:0] LEFT_POINT_BASE  = 4'd11;

   localparam logic [IDX_W-1:0] BATT_BASE     = 4'd3;
   localparam logic [IDX_W-1:0] MARK_MID_BASE = 4'd9;
   localparam logic [IDX_W-1:0] MARK_LEFT_BASE = 4'd14;

   // One classified command as the back end applies it.
   typedef struct packed {
      logic                     clear_all;
      logic                     seg_we;
      logic [IDX_W-1:0]         seg_idx;
      logic [6:0]               seg_code;
      logic [STORE_ENTRIES-1:0] dp_clr;
      logic [STORE_ENTRIES-1:0] dp_set;
      logic                     refresh;
   } cmd_type;

   function automatic logic [6:0] encode_glyph(input logic [7:0] c);
      logic [6:0] code;
      unique case (c)
         8'h2A: code = 7'h33;               // '*'
         8'h7C: code = 7'h05;               // '|'
         8'h2D: code = 7'h02;               // '-'
         8'h5F: code = 7'h08;               // '_'
         8'h30: code = 7'h7D;
         8'h31: code = 7'h60;
         8'h32: code = 7'h3E;
         8'h33: code = 7'h7A;
         8'h34: code = 7'h63;
         8'h35: code = 7'h5B;
         8'h36: code = 7'h5F;
         8'h37: code = 7'h70;
         8'h38: code = 7'h7F;
         8'h39: code = 7'h7B;
         8'h41, 8'h61: code = 7'h77;        // A
         8'h42, 8'h62: code = 7'h4F;        // B
         8'h63:        code = 7'h69;        // lower-case c
         8'h43:        code = 7'h1D;        // upper-case C
         8'h44, 8'h64: code = 7'h6E;
         8'h45, 8'h65: code = 7'h1F;
         8'h46, 8'h66: code = 7'h17;
         8'h47, 8'h67: code = 7'h5D;
         8'h48, 8'h68: code = 7'h67;
         8'h49, 8'h69: code = 7'h60;
         8'h4A, 8'h6A: code = 7'h68;
         8'h4C, 8'h6C: code = 7'h0D;
         8'h4D, 8'h6D: code = 7'h54;
         8'h4E, 8'h6E: code = 7'h46;
         8'h4F, 8'h6F: code = 7'h4E;
         8'h50, 8'h70: code = 7'h37;
         8'h51, 8'h71: code = 7'h73;
         8'h52, 8'h72: code = 7'h06;
         8'h53, 8'h73: code = 7'h5B;
         8'h54, 8'h74: code = 7'h0F;
         8'h55, 8'h75: code = 7'h6D;
         8'h59, 8'h79: code = 7'h6B;
         8'h5A, 8'h7A: code = 7'h3E;
         default:      code = 7'h00;
      endcase
      return code;
   endfunction

endpackage

[rtl/core/segment_lcd_buffer_controller.sv]
// Segment display store controller: command front end, queue and refresh back end.
// A beat accepted into an idle block is held in the queue and then applied by the back end,
// which puts the sixteen store writes on the result ports, one write per cycle.
// A refreshing command waiting in the queue is applied on the edge that takes the last write
// of the refresh before it; a put without end mark or an ignored command starts no readout.
// Reset clears the store to zero, empties the two-entry queue and stops any refresh.
module segment_lcd_buffer_controller (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [2:0] req_op,
   input  logic [1:0] req_section,
   input  logic [2:0] req_slot,
   input  logic [7:0] req_glyph,
   input  logic       req_text_end,
   input  logic [2:0] req_bars,
   input  logic       req_mark_group,
   input  logic       req_mark_up,
   input  logic       req_mark_down,
   input  logic [2:0] req_frac_digits,
   output logic       rsp_strobe,
   output logic [4:0] rsp_ram_address,
   output logic [7:0] rsp_ram_data,
   output logic       rsp_last_write
);
   import slcd_pkg::*;

   logic    push;
   logic    pop;
   logic    queue_empty;
   logic    queue_full;
   cmd_type push_cmd;
   cmd_type pop_cmd;

   slcd_front u_front (
      .start          (start),
      .queue_full     (queue_full),
      .req_op         (req_op),
      .req_section    (req_section),
      .req_slot       (req_slot),
      .req_glyph      (req_glyph),
      .req_text_end   (req_text_end),
      .req_bars       (req_bars),
      .req_mark_group (req_mark_group),
      .req_mark_up    (req_mark_up),
      .req_mark_down  (req_mark_down),
      .req_frac_digits(req_frac_digits),
      .busy           (busy),
      .push           (push),
      .push_cmd       (push_cmd)
   );

   slcd_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .push_cmd(push_cmd),
      .pop     (pop),
      .pop_cmd (pop_cmd),
      .empty   (queue_empty),
      .full    (queue_full)
   );

   slcd_back u_back (
      .clock          (clock),
      .reset          (reset),
      .queue_empty    (queue_empty),
      .cmd            (pop_cmd),
      .pop            (pop),
      .rsp_strobe     (rsp_strobe),
      .rsp_ram_address(rsp_ram_address),
      .rsp_ram_data   (rsp_ram_data),
      .rsp_last_write (rsp_last_write)
   );

endmodule

[rtl/core/slcd_front.sv]
// Front end: takes command beats and turns them into store update commands.
module slcd_front (
   input  logic                 start,
   input  logic                 queue_full,
   input  logic [2:0]           req_op,
   input  logic [1:0]           req_section,
   input  logic [2:0]           req_slot,
   input  logic [7:0]           req_glyph,
   input  logic                 req_text_end,
   input  logic [2:0]           req_bars,
   input  logic                 req_mark_group,
   input  logic                 req_mark_up,
   input  logic                 req_mark_down,
   input  logic [2:0]           req_frac_digits,
   output logic                 busy,
   output logic                 push,
   output slcd_pkg::cmd_type    push_cmd
);
   import slcd_pkg::*;

   logic             keep;
   logic [IDX_W-1:0] point_base;
   logic [IDX_W-1:0] mark_base;
   logic [1:0]       point_k;

   assign busy = queue_full;

   always_comb begin
      keep       = 1'b0;
      push_cmd   = '0;
      point_base = RIGHT_POINT_BASE;
      mark_base  = req_mark_group ? MARK_LEFT_BASE : MARK_MID_BASE;
      point_k    = 2'd3 - req_frac_digits[1:0];
      unique case (req_op)
         OP_PUT: begin
            push_cmd.seg_we   = 1'b1;
            push_cmd.seg_code = encode_glyph(req_glyph);
            push_cmd.refresh  = req_text_end;
            priority if (req_section == SEC_RIGHT) begin
               keep             = req_slot < RIGHT_DIGITS;
               push_cmd.seg_idx = RIGHT_BASE - {1'b0, req_slot};
            end else if (req_section == SEC_MID) begin
               keep             = req_slot < SIDE_DIGITS;
               push_cmd.seg_idx = MID_BASE - {1'b0, req_slot};
            end else if (req_section == SEC_LEFT) begin
               keep             = req_slot < SIDE_DIGITS;
               push_cmd.seg_idx = LEFT_BASE - {1'b0, req_slot};
            end else begin
               keep = 1'b0;
            end
         end
         OP_BATT: begin
            keep             = 1'b1;
            push_cmd.refresh = 1'b1;
            push_cmd.dp_clr  = STORE_ENTRIES'(7) << BATT_BASE;
            unique case (req_bars)
               3'd1:    push_cmd.dp_set = STORE_ENTRIES'(1) << BATT_BASE;
               3'd2:    push_cmd.dp_set = STORE_ENTRIES'(3) << BATT_BASE;
               3'd3:    push_cmd.dp_set = STORE_ENTRIES'(7) << BATT_BASE;
               default: push_cmd.dp_set = '0;
            endcase
         end
         OP_MARK: begin
            keep             = 1'b1;
            push_cmd.refresh = 1'b1;
            push_cmd.dp_clr  = STORE_ENTRIES'(3) << mark_base;
            push_cmd.dp_set  = STORE_ENTRIES'({req_mark_down, req_mark_up}) << mark_base;
         end
         OP_POINT: begin
            keep             = req_section != SEC_NONE;
            push_cmd.refresh = 1'b1;
            unique case (req_section)
               SEC_MID:  point_base = MID_POINT_BASE;
               SEC_LEFT: point_base = LEFT_POINT_BASE;
               default:  point_base = RIGHT_POINT_BASE;
            endcase
            push_cmd.dp_clr = STORE_ENTRIES'(7) << point_base;
            // A point is lit only for one to three fraction digits.
            if (!req_frac_digits[2] && req_frac_digits[1:0] != 2'd0) begin
               push_cmd.dp_set = STORE_ENTRIES'(1) << (point_base + {2'b00, point_k});
            end
         end
         OP_CLEAR: begin
            keep               = 1'b1;
            push_cmd.clear_all = 1'b1;
            push_cmd.refresh   = 1'b1;
         end
         default: keep = 1'b0;
      endcase
   end

   assign push = start && !queue_full && keep;

endmodule

[rtl/core/slcd_queue.sv]
// Two-entry command queue between the front end and the back end.
module slcd_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  slcd_pkg::cmd_type push_cmd,
   input  logic              pop,
   output slcd_pkg::cmd_type pop_cmd,
   output logic              empty,
   output logic              full
);
   import slcd_pkg::*;

   cmd_type           slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign empty   = count_ff == QCNT_W'(0);
   assign full    = count_ff == QCNT_W'(QUEUE_DEPTH);
   assign pop_cmd = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

`ifndef SYNTH
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("command pushed into a full queue");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("command popped from an empty queue");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> count_ff == $past(count_ff) + QCNT_W'(1))
      else $error("queue count did not follow a lone push");
`endif

endmodule

[rtl/core/slcd_back.sv]
// Back end: holds the display store, applies commands and streams the refresh writes.
module slcd_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              queue_empty,
   input  slcd_pkg::cmd_type cmd,
   output logic              pop,
   output logic              rsp_strobe,
   output logic [4:0]        rsp_ram_address,
   output logic [7:0]        rsp_ram_data,
   output logic              rsp_last_write
);
   import slcd_pkg::*;

   logic [7:0]       store_ff [STORE_ENTRIES];
   logic [7:0]       store_in [STORE_ENTRIES];
   logic             stream_ff, stream_in;
   logic [IDX_W-1:0] cnt_ff, cnt_in;
   logic             last_beat;

   assign last_beat = stream_ff && cnt_ff == IDX_W'(STORE_ENTRIES - 1);
   // The next command may be applied on the edge that takes the last beat.
   assign pop       = !queue_empty && (!stream_ff || last_beat);

   always_comb begin
      for (int i = 0; i < STORE_ENTRIES; i++) begin
         store_in[i] = store_ff[i];
         if (pop) begin
            if (cmd.clear_all) begin
               store_in[i] = 8'h00;
            end else begin
               if (cmd.seg_we && cmd.seg_idx == IDX_W'(i)) begin
                  store_in[i][6:0] = cmd.seg_code;
               end
               store_in[i][7] = (store_ff[i][7] && !cmd.dp_clr[i]) || cmd.dp_set[i];
            end
         end
      end
   end

   always_comb begin
      stream_in = stream_ff;
      cnt_in    = cnt_ff;
      if (stream_ff) begin
         cnt_in = cnt_ff + IDX_W'(1);
      end
      if (last_beat) begin
         stream_in = 1'b0;
      end
      if (pop && cmd.refresh) begin
         stream_in = 1'b1;
         cnt_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stream_ff <= 1'b0;
         cnt_ff    <= '0;
         for (int i = 0; i < STORE_ENTRIES; i++) begin
            store_ff[i] <= 8'h00;
         end
      end else begin
         stream_ff <= stream_in;
         cnt_ff    <= cnt_in;
         for (int i = 0; i < STORE_ENTRIES; i++) begin
            store_ff[i] <= store_in[i];
         end
      end
   end

   assign rsp_strobe      = stream_ff;
   assign rsp_ram_address = {cnt_ff, 1'b0};
   assign rsp_ram_data    = store_ff[cnt_ff];
   assign rsp_last_write  = last_beat;

`ifndef SYNTH
   a_last_has_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_last_write |-> rsp_strobe)
      else $error("last write flagged without a beat");
   a_stream_runs_on: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_last_write) |=> rsp_strobe && cnt_ff == $past(cnt_ff) + IDX_W'(1))
      else $error("refresh stream broke off early");
   a_store_steady: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_last_write) |=> $stable(store_ff[0]) && $stable(store_ff[15]))
      else $error("store changed in the middle of a refresh");
`endif

endmodule
